### hdl/twhl_pkg.sv
// Shared types and codes for the two-wire handshake link port.
package twhl_pkg;

  // Transaction kinds carried on the input tuser field
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SEND = 2'd1,
    ACT_RECV = 2'd2
  } action_e;

  // Transfer mode of the port
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned BitIdxW = 3;
  localparam logic [BitIdxW-1:0] LastBit = 3'd7;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  // One result transaction, first field in the highest bits
  typedef struct packed {
    logic             busy_res;
    logic             tx_done;
    logic             rx_done;
    logic [ByteW-1:0] rx_byte;
    logic             white_pull_low;
    logic             red_pull_low;
  } result_t;

endpackage

### hdl/two_wire_handshake_link_port_top.sv
// Two-wire handshake link port: bit-level send/receive controller with stream ports.
// Throughput: one transaction per cycle while the skid slot is empty; all per-step work
// is a single combinational pass between the state registers and the result register,
// and a one-entry skid slot keeps s_axis_tready high while one finished result waits on
// a stalled m_axis. Each result is registered in the output slot or the skid slot.
// Reset: rst_ni clears link state, drives, received byte and both output slots at once.
module two_wire_handshake_link_port_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] red_level, [9] white_level
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] red_pull_low, [1] white_pull_low,
                                     // [9:2] rx_byte, [10] rx_done, [11] tx_done,
                                     // [12] busy_res
);
  import twhl_pkg::*;

  // Link state
  mode_e              mode_q, mode_d;
  logic               phase_q, phase_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               cur_bit_q, cur_bit_d;
  logic               drv_red_q, drv_red_d;
  logic               drv_white_q, drv_white_d;
  logic [ByteW-1:0]   rx_hold_q, rx_hold_d;

  // Output slot and skid slot
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res_d;

  logic             in_acc, out_take;
  action_e          action;
  logic [ByteW-1:0] tx_byte;
  logic             red_lvl, white_lvl;
  logic             idle, ack, rel_line, rx_done, tx_done;
  logic [BitIdxW-1:0] idx_inc;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_take  = m_axis_tvalid && m_axis_tready;
  assign action    = action_e'(s_axis_tuser);
  assign tx_byte   = s_axis_tdata[ByteW-1:0];
  assign red_lvl   = s_axis_tdata[ByteW];
  assign white_lvl = s_axis_tdata[ByteW+1];
  assign idx_inc   = bit_idx_q + BitIdxW'(1);

  // Next link state for one step
  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    cur_bit_d   = cur_bit_q;
    drv_red_d   = drv_red_q;
    drv_white_d = drv_white_q;
    rx_hold_d   = rx_hold_q;
    rx_done     = 1'b0;
    tx_done     = 1'b0;
    idle        = (mode_q != MODE_SEND) && (mode_q != MODE_RECV);
    ack         = cur_bit_q ? red_lvl : white_lvl;
    rel_line    = cur_bit_q ? white_lvl : red_lvl;

    if (idle && action == ACT_SEND) begin
      // Load the byte and drive its first bit
      mode_d      = MODE_SEND;
      bit_idx_d   = '0;
      shift_d     = tx_byte;
      cur_bit_d   = tx_byte[0];
      drv_red_d   = !tx_byte[0];
      drv_white_d = tx_byte[0];
      phase_d     = 1'b0;
    end else if (idle && action == ACT_RECV) begin
      mode_d      = MODE_RECV;
      bit_idx_d   = '0;
      shift_d     = '0;
      cur_bit_d   = 1'b0;
      phase_d     = 1'b0;
      drv_red_d   = 1'b0;
      drv_white_d = 1'b0;
    end else if (mode_q == MODE_SEND) begin
      if (!phase_q) begin
        // Wait for the acknowledging line to go low, then release
        if (!ack) begin
          drv_red_d   = 1'b0;
          drv_white_d = 1'b0;
          phase_d     = 1'b1;
        end
      end else if (ack) begin
        if (bit_idx_q == LastBit) begin
          mode_d    = MODE_IDLE;
          phase_d   = 1'b0;
          bit_idx_d = '0;
          tx_done   = 1'b1;
        end else begin
          // Advance to the next bit and drive it
          bit_idx_d = idx_inc;
          cur_bit_d = shift_q[idx_inc];
          if (shift_q[idx_inc]) begin
            drv_white_d = 1'b1;
          end else begin
            drv_red_d = 1'b1;
          end
          phase_d = 1'b0;
        end
      end
    end else if (mode_q == MODE_RECV) begin
      if (!phase_q) begin
        // Answer the first line that goes low; red wins a tie
        if (!red_lvl) begin
          cur_bit_d   = 1'b0;
          drv_white_d = 1'b1;
          phase_d     = 1'b1;
        end else if (!white_lvl) begin
          cur_bit_d = 1'b1;
          drv_red_d = 1'b1;
          phase_d   = 1'b1;
        end
      end else if (rel_line) begin
        // Sender released its line: drop our pull and shift the bit in
        drv_red_d   = 1'b0;
        drv_white_d = 1'b0;
        shift_d     = shift_q | (ByteW'(cur_bit_q) << bit_idx_q);
        phase_d     = 1'b0;
        if (bit_idx_q == LastBit) begin
          rx_hold_d = shift_d;
          mode_d    = MODE_IDLE;
          bit_idx_d = '0;
          rx_done   = 1'b1;
        end else begin
          bit_idx_d = idx_inc;
        end
      end
    end

    res_d.red_pull_low   = drv_red_d;
    res_d.white_pull_low = drv_white_d;
    res_d.rx_byte        = rx_hold_d;
    res_d.rx_done        = rx_done;
    res_d.tx_done        = tx_done;
    res_d.busy_res       = (mode_d == MODE_SEND) || (mode_d == MODE_RECV);
  end

  // Commit link state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      phase_q     <= 1'b0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      cur_bit_q   <= 1'b0;
      drv_red_q   <= 1'b0;
      drv_white_q <= 1'b0;
      rx_hold_q   <= '0;
    end else if (in_acc) begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
      cur_bit_q   <= cur_bit_d;
      drv_red_q   <= drv_red_d;
      drv_white_q <= drv_white_d;
      rx_hold_q   <= rx_hold_d;
    end
  end

  // Output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payloads
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res_d;
      end
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

  // Never pull both wires at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(drv_red_q && drv_white_q))
    else $error("both wires pulled low");

  // Skid slot is only filled behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot filled with empty output register");

  // An idle port releases both wires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (!drv_red_q && !drv_white_q))
    else $error("wire pulled while idle");

  // A completed byte always ends the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.tx_done || out_q.rx_done)) |-> !out_q.busy_res)
    else $error("done reported while still busy");

endmodule

### dv/tb_two_wire_handshake_link_port_top.sv
// Self-checking testbench for the two-wire handshake link port stream wrapper.
`timescale 1ns / 1ps

module tb_two_wire_handshake_link_port_top;
  import twhl_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [1:0] PhWaitLow = 2'd0;
  localparam logic [1:0] PhWaitHigh = 2'd1;
  localparam int unsigned NumDir = 23;
  localparam int unsigned NumPhases = 4;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned SendIdlePct [NumPhases] = '{0, 66, 0, 15};
  localparam int unsigned RecvStallPct [NumPhases] = '{0, 0, 66, 15};

  // Results that can be read off at a glance
  localparam result_t ResIdle = '0;
  localparam result_t ResBusy = '{busy_res: 1'b1, default: '0};
  localparam result_t ResTxRed = '{busy_res: 1'b1, red_pull_low: 1'b1, default: '0};
  localparam result_t ResRxWhite = '{busy_res: 1'b1, white_pull_low: 1'b1, default: '0};

  typedef struct packed {
    logic [1:0]       act;
    logic [ByteW-1:0] txb;
    logic             red;
    logic             white;
    logic             typed;
    result_t          res;
  } stim_row_t;

  // Directed rows: act, tx_byte, red, white, typed, expected
  localparam stim_row_t DirTbl [NumDir] = '{
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b1, ResIdle},     // tick while idle
    '{ActUnused, 8'hFF, 1'b1, 1'b1, 1'b1, ResIdle},     // unused action while idle
    '{ACT_SEND,  8'h00, 1'b1, 1'b1, 1'b1, ResTxRed},    // start send, lines not sampled
    '{ACT_RECV,  8'hFF, 1'b0, 1'b0, 1'b1, ResBusy},     // request while busy, white acks
    '{ACT_SEND,  8'hAA, 1'b1, 1'b0, 1'b1, ResBusy},     // white still low, hold
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},     // advance to bit 1
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, ResIdle},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},     // last bit acked, send done
    '{ACT_RECV,  8'hFF, 1'b1, 1'b1, 1'b1, ResBusy},     // start receive
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b1, ResRxWhite},  // both lines low, red wins
    '{ACT_TICK,  8'h00, 1'b1, 1'b0, 1'b0, ResIdle}      // red released, bit shifted in
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = ACT_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Link state as the port should hold it
  mode_e              lm_mode = MODE_IDLE;
  logic [1:0]         lm_phase = PhWaitLow;
  logic [BitIdxW-1:0] lm_bit = '0;
  logic [ByteW-1:0]   lm_shift = '0;
  logic               lm_cur = 1'b0;
  logic               lm_red = 1'b0;
  logic               lm_white = 1'b0;
  logic [ByteW-1:0]   lm_rx_hold = '0;

  // Far end of the link: its own pulls and the byte it sends us
  logic               peer_red = 1'b0;
  logic               peer_white = 1'b0;
  logic [ByteW-1:0]   peer_byte = '0;

  result_t     expected_results [$];
  result_t     got_res;
  result_t     want_res;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  two_wire_handshake_link_port_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Put the current bit of the outgoing byte on its wire
  task automatic drive_next_tx_bit();
    lm_cur = lm_shift[lm_bit];
    if (!lm_cur) begin
      lm_red = 1'b1;
    end else begin
      lm_white = 1'b1;
    end
    lm_phase = PhWaitLow;
  endtask

  // Advance the link state by one step and return the result it shows
  task automatic predict_link_step(input logic [1:0] act, input logic [ByteW-1:0] txb,
                                   input logic red, input logic white, output result_t res);
    logic is_idle;
    logic ack;
    logic rx_done;
    logic tx_done;
    is_idle = (lm_mode != MODE_SEND) && (lm_mode != MODE_RECV);
    rx_done = 1'b0;
    tx_done = 1'b0;
    if (is_idle && act == ACT_SEND) begin
      lm_mode = MODE_SEND;
      lm_bit = '0;
      lm_shift = txb;
      lm_red = 1'b0;
      lm_white = 1'b0;
      drive_next_tx_bit();
    end else if (is_idle && act == ACT_RECV) begin
      lm_mode = MODE_RECV;
      lm_bit = '0;
      lm_shift = '0;
      lm_cur = 1'b0;
      lm_phase = PhWaitLow;
      lm_red = 1'b0;
      lm_white = 1'b0;
    end else if (lm_mode == MODE_SEND) begin
      // the acknowledge comes on the wire we are not pulling
      ack = lm_cur ? red : white;
      if (lm_phase == PhWaitLow) begin
        if (!ack) begin
          lm_red = 1'b0;
          lm_white = 1'b0;
          lm_phase = PhWaitHigh;
        end
      end else if (ack) begin
        if (lm_bit == LastBit) begin
          lm_mode = MODE_IDLE;
          lm_phase = PhWaitLow;
          lm_bit = '0;
          tx_done = 1'b1;
        end else begin
          lm_bit = lm_bit + BitIdxW'(1);
          drive_next_tx_bit();
        end
      end
    end else if (lm_mode == MODE_RECV) begin
      if (lm_phase == PhWaitLow) begin
        if (!red) begin
          lm_cur = 1'b0;
          lm_white = 1'b1;
          lm_phase = PhWaitHigh;
        end else if (!white) begin
          lm_cur = 1'b1;
          lm_red = 1'b1;
          lm_phase = PhWaitHigh;
        end
      end else if (lm_cur ? white : red) begin
        lm_red = 1'b0;
        lm_white = 1'b0;
        lm_shift = lm_shift | ({7'd0, lm_cur} << lm_bit);
        lm_phase = PhWaitLow;
        if (lm_bit == LastBit) begin
          lm_rx_hold = lm_shift;
          lm_mode = MODE_IDLE;
          lm_bit = '0;
          rx_done = 1'b1;
        end else begin
          lm_bit = lm_bit + BitIdxW'(1);
        end
      end
    end
    res = '0;
    res.red_pull_low = lm_red;
    res.white_pull_low = lm_white;
    res.rx_byte = lm_rx_hold;
    res.rx_done = rx_done;
    res.tx_done = tx_done;
    res.busy_res = (lm_mode == MODE_SEND) || (lm_mode == MODE_RECV);
  endtask

  // Offer one input transaction, hold it until accepted, then queue its result
  task automatic drive_link_txn(input logic [1:0] act, input logic [ByteW-1:0] txb,
                                input logic red, input logic white,
                                input logic typed, input result_t typed_res);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, white, red, txb};
    s_axis_tuser <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_link_step(act, txb, red, white, pred);
    expected_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (got !== want) report_mismatch(what, 32'(want), 32'(got));
  endtask

  // Stall the result side at the rate of the current phase
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transaction with the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 32'(m_axis_tdata));
      end else begin
        want_res = expected_results.pop_front();
        got_res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        check_field("red_pull_low", ByteW'(want_res.red_pull_low),
                    ByteW'(got_res.red_pull_low));
        check_field("white_pull_low", ByteW'(want_res.white_pull_low),
                    ByteW'(got_res.white_pull_low));
        check_field("rx_byte", want_res.rx_byte, got_res.rx_byte);
        check_field("rx_done", ByteW'(want_res.rx_done), ByteW'(got_res.rx_done));
        check_field("tx_done", ByteW'(want_res.tx_done), ByteW'(got_res.tx_done));
        check_field("busy_res", ByteW'(want_res.busy_res), ByteW'(got_res.busy_res));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_two_wire_handshake_link_port_top: done, errors");
      $finish;
    end
  end

  initial begin
    logic [1:0]       act;
    logic [ByteW-1:0] txb;
    logic             red;
    logic             white;
    logic             is_idle;
    logic             want_red;
    logic             want_white;
    int unsigned      pick;
    int unsigned      counted;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with no idling
    for (int i = 0; i < NumDir; i++) begin
      drive_link_txn(DirTbl[i].act, DirTbl[i].txb, DirTbl[i].red, DirTbl[i].white,
                     DirTbl[i].typed, DirTbl[i].res);
    end

    // Random part: mostly well-formed transfers against a responding far end
    peer_byte = 8'($urandom);
    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct = SendIdlePct[ph];
      recv_stall_pct = RecvStallPct[ph];
      counted = 0;
      while (counted < ItemsPerPhase) begin
        is_idle = (lm_mode != MODE_SEND) && (lm_mode != MODE_RECV);
        txb = 8'($urandom);
        if (is_idle) begin
          pick = $urandom_range(9);
          if (pick < 4) begin
            act = ACT_SEND;
          end else if (pick < 8) begin
            act = ACT_RECV;
            peer_byte = 8'($urandom);
          end else if (pick == 8) begin
            act = ACT_TICK;
          end else begin
            act = ActUnused;
          end
        end else begin
          pick = $urandom_range(31);
          if (pick == 0) begin
            act = ACT_SEND;
          end else if (pick == 1) begin
            act = ACT_RECV;
          end else if (pick == 2) begin
            act = ActUnused;
          end else begin
            act = ACT_TICK;
          end
        end

        // Far end answers our pulls when we send, and leads the bit when we receive
        if (lm_mode == MODE_SEND) begin
          want_red = lm_white;
          want_white = lm_red;
        end else if (lm_mode == MODE_RECV && lm_phase == PhWaitLow) begin
          want_red = ~peer_byte[lm_bit];
          want_white = peer_byte[lm_bit];
        end else begin
          want_red = 1'b0;
          want_white = 1'b0;
        end
        if ($urandom_range(3) != 0) begin
          peer_red = want_red;
          peer_white = want_white;
        end

        // Open-drain wires, with occasional noise
        if ($urandom_range(9) == 0) begin
          red = 1'($urandom_range(1));
          white = 1'($urandom_range(1));
        end else begin
          red = ~(lm_red | peer_red);
          white = ~(lm_white | peer_white);
        end

        drive_link_txn(act, txb, red, white, 1'b0, ResIdle);
        if (!is_idle || act == ACT_SEND || act == ACT_RECV) counted++;
      end
    end

    // Drain outstanding results
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_two_wire_handshake_link_port_top: done, clean");
    end else begin
      $display("tb_two_wire_handshake_link_port_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/twhl_pkg.sv
hdl/two_wire_handshake_link_port_top.sv
dv/tb_two_wire_handshake_link_port_top.sv
